@@ design/svmi_pkg.sv @@
// ----------------------------------------------------------------------------
// svmi_pkg
// types and constants for the slot value table with lowest matching index find
// ----------------------------------------------------------------------------
package svmi_pkg;

    localparam int SLOTS_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // fixed widths of the request and result fields
    localparam int SLOT_FIELD_W  = 10;
    localparam int VALUE_FIELD_W = 32;

    localparam logic FUNC_CHANGE = 1'b0;
    localparam logic FUNC_FIND   = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [SLOT_FIELD_W-1:0]  slot_index;
        logic [VALUE_FIELD_W-1:0] value;
    } svmi_req_t;

    typedef struct packed {
        logic                    found;
        logic [SLOT_FIELD_W-1:0] lowest_slot;
    } svmi_rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } svmi_state_t;

endpackage

@@ design/slot_value_table_min_index_find.sv @@
// ----------------------------------------------------------------------------
// slot_value_table_min_index_find
// slot table in one synchronous memory; a find scans it for the lowest match
// ----------------------------------------------------------------------------
// change request: written to the slot memory at the accept
// find request: one slot per cycle through the single memory read port; the
//   scan stops at the first hit, or after the last slot on a miss
// one request at a time; after a find the next is taken once the result is loaded
// after reset a clearing pass writes every slot empty with req_stall high;
//   rst_n is asynchronous, active low
module slot_value_table_min_index_find
    import svmi_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  svmi_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output svmi_rsp_t rsp
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // entry: valid mark on top of the stored value
    logic [VALUE_BITS:0] mem [SLOTS];
    logic [VALUE_BITS:0] rd_data_reg;

    svmi_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic res_found_reg, res_found_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic out_valid_reg, out_valid_next;
    svmi_rsp_t out_data_reg, out_data_next;

    logic mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [VALUE_BITS:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic hit;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    assign hit = rd_pend_reg && rd_data_reg[VALUE_BITS]
                 && (rd_data_reg[VALUE_BITS-1:0] == key_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        rd_idx_reg    <= rd_idx_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        out_data_reg  <= out_data_next;
    end

    // writes happen only in clear and idle, and only reads issued in scan are
    // compared, so a compared read never meets a write to the same slot
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = cnt_reg[IDX_W-1:0];
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[IDX_W-1:0];
        mem_wdata      = '0;
        mem_raddr      = cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.func == FUNC_FIND)
                    begin
                        key_next   = VALUE_BITS'(req.value);
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else if (32'(req.slot_index) < SLOTS)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = IDX_W'(req.slot_index);
                        mem_wdata = {1'b1, VALUE_BITS'(req.value)};
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_found_next = 1'b1;
                    res_idx_next   = rd_idx_reg;
                    state_next     = ST_DONE;
                end
                else if (cnt_reg < CNT_W'(SLOTS))
                begin
                    // issue the next slot read while comparing the last one
                    rd_pend_next = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                else if (!rd_pend_reg)
                begin
                    res_found_next = 1'b0;
                    res_idx_next   = '0;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.found       = res_found_reg;
                    out_data_next.lowest_slot = SLOT_FIELD_W'(res_idx_reg);
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !mem_we)
        else $error("slot memory written during a scan");

    a_hit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && hit) |=> (state_reg == ST_DONE))
        else $error("match did not end the scan");

    a_find_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.func == FUNC_FIND)
        |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("find request did not start a scan at slot zero");

    a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |-> (rsp.lowest_slot == '0))
        else $error("not-found result carries a nonzero slot");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CNT_W'(SLOTS)))
        else $error("scan counter ran past the table");

endmodule

@@ test/slot_value_table_min_index_find_test.sv @@
// ----------------------------------------------------------------------------
// slot_value_table_min_index_find_test
// self-checking bench for the slot table with lowest matching index find;
// a shadow copy of the table predicts every find, and random idling plus one
// long result hold-off exercise both handshakes
// ----------------------------------------------------------------------------
module slot_value_table_min_index_find_test;
    import svmi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_REQS = 560;
    localparam int POOL_SIZE   = 12;
    localparam logic [VALUE_FIELD_W-1:0] VALUE_MASK = {VALUE_FIELD_W{1'b1}} >>
                                                      (VALUE_FIELD_W - VALUE_BITS_DEF);

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    svmi_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    svmi_rsp_t rsp;

    // shadow of the slot table, updated at each change request accept
    logic [VALUE_FIELD_W-1:0] shadow_value [SLOTS_DEF];
    bit                       shadow_valid [SLOTS_DEF];

    svmi_req_t pending_reqs [$];
    svmi_rsp_t expected_rsps [$];

    int error_count  = 0;
    int sent_count   = 0;
    int rsp_count    = 0;
    int change_count = 0;
    int hit_count    = 0;
    int miss_count   = 0;
    int cycle_count  = 0;
    int hold_left    = 0;
    bit held_once    = 1'b0;

    logic [VALUE_FIELD_W-1:0] value_pool [POOL_SIZE];
    logic [VALUE_FIELD_W-1:0] written_vals [$];

    slot_value_table_min_index_find u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // applies one accepted request to the shadow table, queues the find answer
    task automatic table_apply(input svmi_req_t r);
        svmi_rsp_t answer;
        logic [VALUE_FIELD_W-1:0] key;
        answer = '0;
        key = r.value & VALUE_MASK;
        if (r.func == FUNC_CHANGE)
        begin
            change_count++;
            if (r.slot_index < SLOTS_DEF)
            begin
                shadow_value[r.slot_index] = key;
                shadow_valid[r.slot_index] = 1'b1;
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS_DEF; i++)
            begin
                if (!answer.found && shadow_valid[i] && shadow_value[i] == key)
                begin
                    answer.found       = 1'b1;
                    answer.lowest_slot = i[SLOT_FIELD_W-1:0];
                end
            end
            if (answer.found)
                hit_count++;
            else
                miss_count++;
            expected_rsps.push_back(answer);
        end
    endtask

    task automatic add_req(input logic f, input int slot, input logic [31:0] val);
        svmi_req_t r;
        r.func       = f;
        r.slot_index = slot[SLOT_FIELD_W-1:0];
        r.value      = val;
        pending_reqs.push_back(r);
        if (f == FUNC_CHANGE)
        begin
            written_vals.push_back(val);
            if (written_vals.size() > 32)
                void'(written_vals.pop_front());
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                table_apply(req);
                sent_count <= sent_count + 1;
            end
            if (!req_valid || !req_stall)
            begin
                // no gaps while the sent count is in the quiet window
                if (pending_reqs.size() != 0 &&
                    ((sent_count >= 250 && sent_count < 330) || $urandom_range(99) >= 21))
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result stall, with one long hold-off so the block backs up
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!held_once && rsp_count >= 60)
            begin
                held_once <= 1'b1;
                hold_left <= 500;
                rsp_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_stall <= 1'b1;
            end
            else if (rsp_count >= 100 && rsp_count < 140)
            begin
                rsp_stall <= 1'b0;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < 21);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        svmi_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_count <= rsp_count + 1;
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected result found=%0d lowest_slot=%0d",
                         $time, rsp.found, rsp.lowest_slot);
                error_count++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.found !== want.found)
                begin
                    $display("%0t: found mismatch, expected %0d actual %0d",
                             $time, want.found, rsp.found);
                    error_count++;
                end
                if (rsp.lowest_slot !== want.lowest_slot)
                begin
                    $display("%0t: lowest_slot mismatch, expected %0d actual %0d",
                             $time, want.lowest_slot, rsp.lowest_slot);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int r;
        logic [31:0] v;

        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;

        // directed: empty table, extremes, lowest of several, overwrite, rewrite
        add_req(FUNC_FIND,   0,     32'h0000_0000);
        add_req(FUNC_FIND,   1023,  32'hFFFF_FFFF);
        add_req(FUNC_CHANGE, 0,     32'h0000_0000);
        add_req(FUNC_CHANGE, 1023,  32'hFFFF_FFFF);
        add_req(FUNC_FIND,   0,     32'h0000_0000);
        add_req(FUNC_FIND,   0,     32'hFFFF_FFFF);
        add_req(FUNC_CHANGE, 512,   32'hFFFF_FFFF);
        add_req(FUNC_FIND,   1023,  32'hFFFF_FFFF);
        add_req(FUNC_CHANGE, 5,     32'hA5A5_A5A5);
        add_req(FUNC_CHANGE, 3,     32'hA5A5_A5A5);
        add_req(FUNC_FIND,   0,     32'hA5A5_A5A5);
        add_req(FUNC_CHANGE, 3,     32'hA5A5_A5A5);
        add_req(FUNC_FIND,   0,     32'hA5A5_A5A5);
        add_req(FUNC_CHANGE, 3,     32'h5A5A_5A5A);
        add_req(FUNC_FIND,   0,     32'hA5A5_A5A5);
        add_req(FUNC_FIND,   0,     32'h5A5A_5A5A);
        add_req(FUNC_CHANGE, 0,     32'h0000_0001);
        add_req(FUNC_FIND,   0,     32'h0000_0000);
        add_req(FUNC_FIND,   0,     32'h0000_0001);
        add_req(FUNC_CHANGE, 'h155, 32'h5555_5555);
        add_req(FUNC_CHANGE, 'h2AA, 32'hAAAA_AAAA);
        add_req(FUNC_FIND,   'h3FF, 32'h5555_5555);
        add_req(FUNC_FIND,   'h155, 32'hAAAA_AAAA);

        // random: mostly writes to low slots from a small value pool, mixed with finds
        // for recent values so scans end early; some random values miss
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                v = ($urandom_range(99) < 60) ? value_pool[$urandom_range(POOL_SIZE-1)]
                                              : $urandom;
                add_req(FUNC_CHANGE,
                        ($urandom_range(99) < 80) ? $urandom_range(63)
                                                  : $urandom_range(1023), v);
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 70 && written_vals.size() != 0)
                    v = written_vals[$urandom_range(written_vals.size()-1)];
                else if (r < 85)
                    v = value_pool[$urandom_range(POOL_SIZE-1)];
                else
                    v = $urandom;
                add_req(FUNC_FIND, $urandom_range(1023), v);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        // a find takes up to a full scan; catch any stray result after the last
        repeat (SLOTS_DEF + 16) @(posedge clk);

        $display("covered %0d changes and %0d finds (%0d hits, %0d misses)",
                 change_count, hit_count + miss_count, hit_count, miss_count);
        $display("with random gaps on both sides and one long result hold-off");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
